FILE: hw/rtl/at_response_line_classifier_defines.svh
// Assertion macros for the AT response line classifier.
// Each macro takes a label, clock, reset, condition(s) and a message.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define ATRLC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ATRLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ATRLC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define ATRLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/atrlc_pkg.sv
package atrlc_pkg;

  localparam int WIN_BYTES = 12;
  localparam int WIN_W     = 8 * WIN_BYTES;

  // Operation codes of an input beat
  localparam logic OP_RX_BYTE  = 1'b0;
  localparam logic OP_CMD_SENT = 1'b1;

  // Ready codes
  localparam logic [1:0] READY_PENDING    = 2'd0;
  localparam logic [1:0] READY_OK         = 2'd1;
  localparam logic [1:0] READY_ERROR      = 2'd2;
  localparam logic [1:0] READY_NO_CARRIER = 2'd3;

  localparam logic [3:0] COUNT_MAX = 4'd15;

  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Patterns, first character in the most significant byte
  localparam logic [15:0] PAT_AT         = 16'h4154;
  localparam logic [15:0] PAT_CRLF       = 16'h0D0A;
  localparam logic [31:0] PAT_OK         = 32'h4F4B_0D0A;
  localparam logic [55:0] PAT_ERROR      = 56'h45_5252_4F52_0D0A;
  localparam logic [95:0] PAT_NO_CARRIER = 96'h4E4F_2043_4152_5249_4552_0D0A;

  localparam logic [3:0] LEN_AT         = 4'd2;
  localparam logic [3:0] LEN_CRLF       = 4'd2;
  localparam logic [3:0] LEN_OK         = 4'd4;
  localparam logic [3:0] LEN_ERROR      = 4'd7;
  localparam logic [3:0] LEN_NO_CARRIER = 4'd12;

  typedef struct packed {
    logic crlf;
    logic ok;
    logic error;
    logic no_carrier;
  } match_t;

  typedef struct packed {
    logic [1:0] ready_code;
    logic       response_done;
    logic       echo_line;
    logic       urc_line;
    logic       line_activity;
    logic       dtr_high;
  } result_t;

  function automatic logic is_blank(input logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

endpackage

FILE: hw/rtl/atrlc_suffix_match.sv
module atrlc_suffix_match
  import atrlc_pkg::*;
(
  input  logic [WIN_W-1:0] window,
  input  logic [3:0]       count,
  output match_t           match
);

  // Newest byte sits in the low byte; a suffix counts only if the line holds it all
  always_comb begin
    match.crlf       = (count >= LEN_CRLF) && (window[15:0] == PAT_CRLF);
    match.ok         = (count >= LEN_OK) && (window[31:0] == PAT_OK);
    match.error      = (count >= LEN_ERROR) && (window[55:0] == PAT_ERROR);
    match.no_carrier = (count >= LEN_NO_CARRIER) && (window[95:0] == PAT_NO_CARRIER);
  end

endmodule

FILE: hw/rtl/atrlc_classify.sv
module atrlc_classify
  import atrlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       operation,
  input  logic [7:0] rx_byte,
  input  logic       low_power,
  output result_t    result
);

  logic [WIN_W-1:0] window;
  logic [WIN_W-1:0] window_next;
  logic [3:0]       count;
  logic [3:0]       count_next;
  logic [15:0]      lead;
  logic [15:0]      lead_next;
  logic             has_text;
  logic             has_text_next;
  logic             in_resp;
  logic             in_resp_next;
  logic [1:0]       ready;
  logic [1:0]       ready_next;

  logic [WIN_W-1:0] win_shift;
  logic [3:0]       cnt_inc;
  logic [15:0]      lead_upd;
  logic             text_upd;
  logic [1:0]       ready_cand;
  logic             clear;
  match_t           match;

  assign win_shift = {window[WIN_W-9:0], rx_byte};
  assign cnt_inc   = (count == COUNT_MAX) ? count : count + 4'd1;
  assign text_upd  = has_text | ~is_blank(rx_byte);

  always_comb begin
    lead_upd = lead;
    if (count == 4'd0) begin
      lead_upd = {rx_byte, 8'h00};
    end else if (count == 4'd1) begin
      lead_upd = {lead[15:8], rx_byte};
    end
  end

  atrlc_suffix_match u_match (
    .window (win_shift),
    .count  (cnt_inc),
    .match  (match)
  );

  always_comb begin
    window_next   = window;
    count_next    = count;
    lead_next     = lead;
    has_text_next = has_text;
    in_resp_next  = in_resp;
    ready_next    = ready;
    ready_cand    = ready;
    clear         = 1'b0;
    result        = '0;

    if (operation == OP_CMD_SENT) begin
      // drop back to idle, keep the collected line
      in_resp_next = 1'b0;
      ready_next   = READY_PENDING;
    end else begin
      window_next   = win_shift;
      count_next    = cnt_inc;
      lead_next     = lead_upd;
      has_text_next = text_upd;
      if (!in_resp) begin
        if (match.crlf) begin
          clear = 1'b1;
          if ((cnt_inc >= LEN_AT) && (lead_upd == PAT_AT)) begin
            in_resp_next     = 1'b1;
            result.echo_line = 1'b1;
          end else if (text_upd) begin
            result.urc_line      = 1'b1;
            result.line_activity = 1'b1;
          end
        end
      end else if (rx_byte == CHAR_LF) begin
        result.line_activity = 1'b1;
        if (match.ok) begin
          ready_cand = READY_OK;
        end else if (match.error) begin
          ready_cand = READY_ERROR;
        end else if (match.no_carrier) begin
          ready_cand = READY_NO_CARRIER;
        end
        ready_next = ready_cand;
        if (ready_cand != READY_PENDING) begin
          result.response_done = 1'b1;
          result.dtr_high      = low_power;
          in_resp_next         = 1'b0;
          clear                = 1'b1;
        end
      end
      // window bytes older than the line are masked by the count
      if (clear) begin
        count_next    = 4'd0;
        lead_next     = 16'h0000;
        has_text_next = 1'b0;
      end
    end
    result.ready_code = ready_next;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= 4'd0;
      lead     <= 16'h0000;
      has_text <= 1'b0;
      in_resp  <= 1'b0;
      ready    <= READY_OK;
    end else if (step) begin
      count    <= count_next;
      lead     <= lead_next;
      has_text <= has_text_next;
      in_resp  <= in_resp_next;
      ready    <= ready_next;
    end
  end

endmodule

FILE: hw/rtl/at_response_line_classifier.sv
// Path: an accepted input beat passes the input register, then the result register, to its result beat.
// Throughput: one beat per cycle unless out_ready stalls the output; the line state
// updates once per beat and the next beat in the input register sees it in the following cycle.
// Reset (rst, synchronous, active high): idle mode, empty line, ready code 1,
// low power mode off, both pipeline registers empty.
`include "at_response_line_classifier_defines.svh"

module at_response_line_classifier
  import atrlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       low_power_mode,
  // input beat channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] rx_byte,
  // result beat channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] ready_code,
  output logic       response_done,
  output logic       echo_line,
  output logic       urc_line,
  output logic       line_activity,
  output logic       dtr_high
);

  // Configuration register: a write is always taken at once.
  logic low_power;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_power <= 1'b0;
    end else if (cfg_valid) begin
      low_power <= low_power_mode;
    end
  end

  // Input register: holds one beat until the classifier can pass its result on.
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;
  logic       advance;
  result_t    result;

  // Move the held beat forward when the result register is free or drains now.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op   <= operation;
      s1_byte <= rx_byte;
    end
  end

  // Classifier: line state and the suffix compares, updated once per advanced beat.
  atrlc_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .operation (s1_op),
    .rx_byte   (s1_byte),
    .low_power (low_power),
    .result    (result)
  );

  // Result register: load on advance, otherwise hold until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ready_code    <= result.ready_code;
      response_done <= result.response_done;
      echo_line     <= result.echo_line;
      urc_line      <= result.urc_line;
      line_activity <= result.line_activity;
      dtr_high      <= result.dtr_high;
    end
  end

  // A completion always leaves a final code behind.
  `ATRLC_ASSERT_NOW(a_done_code, clk, rst, out_valid && response_done, ready_code != READY_PENDING, "completion with pending ready code")
  // DTR is raised only together with a completion.
  `ATRLC_ASSERT_NOW(a_dtr_done, clk, rst, out_valid && dtr_high, response_done, "dtr_high without response_done")
  // An unsolicited line always refreshes the activity time.
  `ATRLC_ASSERT_NOW(a_urc_act, clk, rst, out_valid && urc_line, line_activity, "urc_line without line_activity")
  // Input stalls only when both registers are full and the output is blocked.
  `ATRLC_ASSERT_NOW(a_stall_full, clk, rst, !in_ready, s1_valid && out_valid && !out_ready, "input stalled with room in the pipeline")

endmodule
